// File: hdl/cfe_pkg.sv
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types and constants of the column foreground extent finder.
// ----------------------------------------------------------------------------
package cfe_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int CHAN_W     = 8;
    localparam int TOL_W      = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_BG_CHAN0     = 3'd2,
        CFG_BG_CHAN1     = 3'd3,
        CFG_BG_CHAN2     = 3'd4,
        CFG_TOLERANCE    = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic last_col;
    } t_pos_flags;

endpackage

// File: hdl/cfe_front.sv
// ----------------------------------------------------------------------------
// cfe_front
// Raster position tracking and per-channel distance to the background color.
// ----------------------------------------------------------------------------
module cfe_front import cfe_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [CHAN_W-1:0] i_chan0,
    input  logic [CHAN_W-1:0] i_chan1,
    input  logic [CHAN_W-1:0] i_chan2,
    input  logic              i_frame_start,
    input  logic [WW-1:0]     i_width,
    input  logic [HW-1:0]     i_height,
    input  logic [CHAN_W-1:0] i_bg0,
    input  logic [CHAN_W-1:0] i_bg1,
    input  logic [CHAN_W-1:0] i_bg2,
    output logic              o_valid,
    output logic [CW-1:0]     o_col,
    output logic [RW-1:0]     o_row,
    output t_pos_flags        o_flags,
    output logic [CHAN_W-1:0] o_dist0,
    output logic [CHAN_W-1:0] o_dist1,
    output logic [CHAN_W-1:0] o_dist2
);

    logic [CW-1:0]     r_col_count;
    logic [RW-1:0]     r_row_count;
    logic [CW-1:0]     n_col_count;
    logic [RW-1:0]     n_row_count;
    logic [CW-1:0]     col;
    logic [RW-1:0]     row;
    t_pos_flags        flags;
    logic              r_valid;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    t_pos_flags        r_flags;
    logic [CHAN_W-1:0] r_dist0;
    logic [CHAN_W-1:0] r_dist1;
    logic [CHAN_W-1:0] r_dist2;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        col = i_frame_start ? '0 : r_col_count;
        row = i_frame_start ? '0 : r_row_count;
        if (32'(col) >= 32'(i_width)) begin
            col = '0;
        end
        if (32'(row) >= 32'(i_height)) begin
            row = '0;
        end
        flags.first_row = (row == '0);
        flags.last_row  = (32'(row) + 32'd1 == 32'(i_height));
        flags.last_col  = (32'(col) + 32'd1 == 32'(i_width));
        n_col_count = col + CW'(1);
        n_row_count = row;
        if (flags.last_col) begin
            n_col_count = '0;
            n_row_count = flags.last_row ? '0 : row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_valid     <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_col_count <= n_col_count;
                r_row_count <= n_row_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col   <= col;
            r_row   <= row;
            r_flags <= flags;
            r_dist0 <= abs_diff(i_chan0, i_bg0);
            r_dist1 <= abs_diff(i_chan1, i_bg1);
            r_dist2 <= abs_diff(i_chan2, i_bg2);
        end
    end

    assign o_valid = r_valid;
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_flags = r_flags;
    assign o_dist0 = r_dist0;
    assign o_dist1 = r_dist1;
    assign o_dist2 = r_dist2;

endmodule

// File: hdl/cfe_column_store.sv
// ----------------------------------------------------------------------------
// cfe_column_store
// Background test, per-column extent memory and its read-modify-write update.
// ----------------------------------------------------------------------------
module cfe_column_store import cfe_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [CW-1:0]     i_col,
    input  logic [RW-1:0]     i_row,
    input  t_pos_flags        i_flags,
    input  logic [CHAN_W-1:0] i_dist0,
    input  logic [CHAN_W-1:0] i_dist1,
    input  logic [CHAN_W-1:0] i_dist2,
    input  logic [TOL_W-1:0]  i_tolerance,
    input  logic [HW-1:0]     i_height,
    output logic              o_valid,
    output logic [CW-1:0]     o_col,
    output logic [HW-1:0]     o_top,
    output logic [RW-1:0]     o_bottom,
    output logic              o_last_col
);

    logic              r_v2;
    logic [CW-1:0]     r_col2;
    logic [RW-1:0]     r_row2;
    t_pos_flags        r_flags2;
    logic              r_fg2;
    logic              r_v3;
    logic [CW-1:0]     r_col3;
    logic [RW-1:0]     r_row3;
    t_pos_flags        r_flags3;
    logic              r_fg3;
    logic [HW+RW-1:0]  r_mem [MAX_WIDTH];
    logic [HW+RW-1:0]  r_rd_data;
    logic              r_fwd_valid;
    logic [CW-1:0]     r_fwd_col;
    logic [HW+RW-1:0]  r_fwd_data;
    logic [HW+RW-1:0]  old_entry;
    logic [HW-1:0]     old_top;
    logic [RW-1:0]     old_bottom;
    logic [HW-1:0]     n_top;
    logic [RW-1:0]     n_bottom;
    logic              fg1;

    assign fg1 = !(({1'b0, i_dist0} < i_tolerance) &&
                   ({1'b0, i_dist1} < i_tolerance) &&
                   ({1'b0, i_dist2} < i_tolerance));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (i_adv) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            if (r_v3) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col2   <= i_col;
            r_row2   <= i_row;
            r_flags2 <= i_flags;
            r_fg2    <= fg1;
            r_col3   <= r_col2;
            r_row3   <= r_row2;
            r_flags3 <= r_flags2;
            r_fg3    <= r_fg2;
            r_rd_data <= r_mem[r_col2];
            if (r_v3) begin
                r_mem[r_col3] <= {n_top, n_bottom};
                r_fwd_col     <= r_col3;
                r_fwd_data    <= {n_top, n_bottom};
            end
        end
    end

    // The entry written in the same cycle as the read is taken from the bypass.
    always_comb begin
        old_entry  = (r_fwd_valid && r_fwd_col == r_col3) ? r_fwd_data : r_rd_data;
        old_top    = old_entry[HW+RW-1:RW];
        old_bottom = old_entry[RW-1:0];
        n_top      = old_top;
        n_bottom   = old_bottom;
        if (r_flags3.first_row) begin
            n_top    = r_fg3 ? '0 : i_height;
            n_bottom = '0;
        end else if (r_fg3) begin
            if (old_top > HW'(r_row3)) begin
                n_top = HW'(r_row3);
            end
            n_bottom = r_row3;
        end
    end

    assign o_valid    = r_v3 && r_flags3.last_row;
    assign o_col      = r_col3;
    assign o_top      = n_top;
    assign o_bottom   = n_bottom;
    assign o_last_col = r_flags3.last_col;

endmodule

// File: hdl/column_foreground_extent_finder_core.sv
// ----------------------------------------------------------------------------
// column_foreground_extent_finder_core
// Per-column first and last foreground row of a raster pixel stream.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock cycle while the output is not
// stalled and delivers each column's extent while the last row of a frame
// streams in, through the front, column-store and output registers. The
// rate is set by the single column memory, read and written once per item;
// back-to-back updates of one column are served by a bypass register.
// The memory holds no defined contents after reset and needs no clearing
// pass, since the first row of every frame writes each column afresh.
module column_foreground_extent_finder_core import cfe_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CHAN_W-1:0]     i_chan0,
    input  logic [CHAN_W-1:0]     i_chan1,
    input  logic [CHAN_W-1:0]     i_chan2,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [10:0]           o_column,
    output logic [11:0]           o_top_row,
    output logic [10:0]           o_bottom_row,
    output logic                  o_last_column,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic [CHAN_W-1:0]     r_bg0;
    logic [CHAN_W-1:0]     r_bg1;
    logic [CHAN_W-1:0]     r_bg2;
    logic [TOL_W-1:0]      r_tolerance;
    logic [WW-1:0]         width_eff;
    logic [HW-1:0]         height_eff;
    logic                  adv;
    logic                  s1_valid;
    logic [CW-1:0]         s1_col;
    logic [RW-1:0]         s1_row;
    t_pos_flags            s1_flags;
    logic [CHAN_W-1:0]     s1_dist0;
    logic [CHAN_W-1:0]     s1_dist1;
    logic [CHAN_W-1:0]     s1_dist2;
    logic                  s3_valid;
    logic [CW-1:0]         s3_col;
    logic [HW-1:0]         s3_top;
    logic [RW-1:0]         s3_bottom;
    logic                  s3_last_col;
    logic                  r_o_valid;
    logic [10:0]           r_column;
    logic [11:0]           r_top_row;
    logic [10:0]           r_bottom_row;
    logic                  r_last_column;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 12'd640;
            r_frame_height <= 12'd480;
            r_bg0          <= '0;
            r_bg1          <= '0;
            r_bg2          <= '0;
            r_tolerance    <= 9'd100;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_BG_CHAN0:     r_bg0          <= i_cfg_data[CHAN_W-1:0];
                CFG_BG_CHAN1:     r_bg1          <= i_cfg_data[CHAN_W-1:0];
                CFG_BG_CHAN2:     r_bg2          <= i_cfg_data[CHAN_W-1:0];
                CFG_TOLERANCE:    r_tolerance    <= i_cfg_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_frame_width == '0) begin
            width_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            height_eff = HW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            height_eff = HW'(MAX_HEIGHT);
        end else begin
            height_eff = HW'(r_frame_height);
        end
    end

    assign adv     = !r_o_valid || i_ready;
    assign o_ready = adv;

    cfe_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_valid      (i_valid),
        .i_chan0      (i_chan0),
        .i_chan1      (i_chan1),
        .i_chan2      (i_chan2),
        .i_frame_start(i_frame_start),
        .i_width      (width_eff),
        .i_height     (height_eff),
        .i_bg0        (r_bg0),
        .i_bg1        (r_bg1),
        .i_bg2        (r_bg2),
        .o_valid      (s1_valid),
        .o_col        (s1_col),
        .o_row        (s1_row),
        .o_flags      (s1_flags),
        .o_dist0      (s1_dist0),
        .o_dist1      (s1_dist1),
        .o_dist2      (s1_dist2)
    );

    cfe_column_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (s1_valid),
        .i_col      (s1_col),
        .i_row      (s1_row),
        .i_flags    (s1_flags),
        .i_dist0    (s1_dist0),
        .i_dist1    (s1_dist1),
        .i_dist2    (s1_dist2),
        .i_tolerance(r_tolerance),
        .i_height   (height_eff),
        .o_valid    (s3_valid),
        .o_col      (s3_col),
        .o_top      (s3_top),
        .o_bottom   (s3_bottom),
        .o_last_col (s3_last_col)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_column      <= 11'(s3_col);
            r_top_row     <= 12'(s3_top);
            r_bottom_row  <= 11'(s3_bottom);
            r_last_column <= s3_last_col;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_column      = r_column;
    assign o_top_row     = r_top_row;
    assign o_bottom_row  = r_bottom_row;
    assign o_last_column = r_last_column;

endmodule

// File: verif/column_foreground_extent_finder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_foreground_extent_finder_core_test
// Self-checking bench for the per-column foreground extent finder.
// ----------------------------------------------------------------------------
// Pixel items are pushed through the valid/ready input while the result side
// stalls at random. A behavioral model of the column stores predicts every
// extent report, and each report is compared field by field in arrival order.
// A short table of hand-built frames comes first. It is followed by a row at
// the widest size setting, a tall two-column frame, and then by many small
// frames with random settings.
// ----------------------------------------------------------------------------
module column_foreground_extent_finder_core_test;
    import cfe_pkg::*;

    localparam int MAX_DIM        = 2048;
    localparam int IDLE_PCT       = 19;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 800;
    localparam int WIDE_PIXELS    = 256;
    localparam int TALL_ROWS      = 150;

    typedef struct packed {
        logic [10:0] column;
        logic [11:0] top_row;
        logic [10:0] bottom_row;
        logic        last_column;
    } extent_t;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic       frame_start;
        logic       typed;
        extent_t    extent;
    } directed_row_t;

    localparam extent_t NONE = '0;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic [CHAN_W-1:0]     i_chan0       = '0;
    logic [CHAN_W-1:0]     i_chan1       = '0;
    logic [CHAN_W-1:0]     i_chan2       = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [10:0]           o_column;
    logic [11:0]           o_top_row;
    logic [10:0]           o_bottom_row;
    logic                  o_last_column;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_index            i_cfg_index   = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic [11:0] cfg_width  = 12'd640;
    logic [11:0] cfg_height = 12'd480;
    logic [7:0]  cfg_bg [3] = '{8'd0, 8'd0, 8'd0};
    logic [8:0]  cfg_tol    = 9'd100;

    int          col_pos = 0;
    int          row_pos = 0;
    logic [11:0] top_rows    [MAX_DIM];
    logic [10:0] bottom_rows [MAX_DIM];

    extent_t       pending_extents [$];
    directed_row_t directed_rows [20];
    int            mismatches = 0;
    logic          calm = 1'b0;

    column_foreground_extent_finder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_chan0       (i_chan0),
        .i_chan1       (i_chan1),
        .i_chan2       (i_chan2),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_column      (o_column),
        .o_top_row     (o_top_row),
        .o_bottom_row  (o_bottom_row),
        .o_last_column (o_last_column),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input logic [11:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic near_bg(input logic [7:0] a, input logic [7:0] b);
        int diff;
        diff = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return diff < int'(cfg_tol);
    endfunction

    task automatic predict_extent(input logic [7:0] c0, input logic [7:0] c1,
                                  input logic [7:0] c2, input logic fs,
                                  output logic emits, output extent_t ext);
        int   w;
        int   h;
        int   col;
        int   row;
        logic fg;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        col = col_pos;
        row = row_pos;
        fg = !(near_bg(c0, cfg_bg[0]) && near_bg(c1, cfg_bg[1]) && near_bg(c2, cfg_bg[2]));
        if (row == 0) begin
            top_rows[col]    = fg ? 12'd0 : 12'(h);
            bottom_rows[col] = '0;
        end else if (fg) begin
            if (top_rows[col] > row) top_rows[col] = 12'(row);
            bottom_rows[col] = 11'(row);
        end
        emits           = (row == h - 1);
        ext.column      = 11'(col);
        ext.top_row     = top_rows[col];
        ext.bottom_row  = bottom_rows[col];
        ext.last_column = (col == w - 1);
        col_pos = col + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input logic fs,
                              input logic typed, input extent_t typed_ext);
        logic    emits;
        extent_t ext;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_chan0       <= c0;
        i_chan1       <= c1;
        i_chan2       <= c2;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_extent(c0, c1, c2, fs, emits, ext);
        if (emits) pending_extents.push_back(typed ? typed_ext : ext);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FRAME_WIDTH:  cfg_width  = data;
            CFG_FRAME_HEIGHT: cfg_height = data;
            CFG_BG_CHAN0:     cfg_bg[0]  = data[7:0];
            CFG_BG_CHAN1:     cfg_bg[1]  = data[7:0];
            CFG_BG_CHAN2:     cfg_bg[2]  = data[7:0];
            CFG_TOLERANCE:    cfg_tol    = data[8:0];
            default: ;
        endcase
    endtask

    task automatic drain_extents();
        i_valid <= 1'b0;
        while (pending_extents.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Background-like channels sit inside the tolerance band or on its edge;
    // the others are anywhere in range or just outside the band.
    function automatic logic [7:0] chan_value(input logic [7:0] bg, input logic bg_like);
        int b;
        int d;
        int v;
        b = int'(bg);
        if (!bg_like && $urandom_range(2) == 0) return 8'($urandom_range(255));
        if (bg_like && $urandom_range(99) < 85)
            d = (cfg_tol == 0) ? 0 : int'($urandom_range(int'(cfg_tol) - 1));
        else if (bg_like || $urandom_range(1))
            d = int'(cfg_tol);
        else
            d = int'(cfg_tol) + int'($urandom_range(40));
        if (d > 255) d = 255;
        v = $urandom_range(1) ? b + d : b - d;
        if (v > 255) v = b - d;
        else if (v < 0) v = b + d;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic make_pixel(output logic [7:0] c0, output logic [7:0] c1,
                              output logic [7:0] c2);
        logic bg_like;
        bg_like = 1'($urandom_range(1));
        c0 = chan_value(cfg_bg[0], bg_like);
        c1 = chan_value(cfg_bg[1], bg_like);
        c2 = chan_value(cfg_bg[2], bg_like);
    endtask

    task automatic check_field(input string label, input int want, input int seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        extent_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_extents.size() == 0) begin
                $display("%0t: extra report, expected none, actual column %0d top %0d bottom %0d",
                         $time, o_column, o_top_row, o_bottom_row);
                mismatches++;
            end else begin
                want = pending_extents.pop_front();
                check_field("column", int'(want.column), int'(o_column));
                check_field("top_row", int'(want.top_row), int'(o_top_row));
                check_field("bottom_row", int'(want.bottom_row), int'(o_bottom_row));
                check_field("last_column", int'(want.last_column), int'(o_last_column));
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("column_foreground_extent_finder_core test failed");
        $finish;
    end

    initial begin
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic        start;
        logic        hot;
        int          old_w;
        int          phase_len;
        int          random_pixels;
        logic [11:0] w_val;
        logic [11:0] h_val;
        logic [8:0]  tol_val;

        // Three columns by three rows, background (100,150,200), tolerance 10.
        directed_rows = '{
            '{8'd100, 8'd150, 8'd200, 1'b1, 1'b0, NONE},
            '{8'd109, 8'd141, 8'd209, 1'b0, 1'b0, NONE},
            '{8'd110, 8'd150, 8'd200, 1'b0, 1'b0, NONE},
            '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NONE},
            '{8'd100, 8'd159, 8'd191, 1'b0, 1'b0, NONE},
            '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, NONE},
            '{8'd100, 8'd150, 8'd200, 1'b0, 1'b1, '{11'd0, 12'd1, 11'd1, 1'b0}},
            '{8'd101, 8'd151, 8'd199, 1'b0, 1'b1, '{11'd1, 12'd3, 11'd0, 1'b0}},
            '{8'd91,  8'd150, 8'd200, 1'b0, 1'b1, '{11'd2, 12'd0, 11'd1, 1'b1}},
            '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, NONE},
            '{8'd255, 8'd0,   8'd255, 1'b0, 1'b0, NONE},
            '{8'd100, 8'd150, 8'd200, 1'b1, 1'b0, NONE},
            '{8'd100, 8'd140, 8'd200, 1'b0, 1'b0, NONE},
            '{8'd100, 8'd150, 8'd200, 1'b0, 1'b0, NONE},
            '{8'd100, 8'd150, 8'd200, 1'b0, 1'b0, NONE},
            '{8'd100, 8'd150, 8'd200, 1'b0, 1'b0, NONE},
            '{8'd90,  8'd150, 8'd200, 1'b0, 1'b0, NONE},
            '{8'd100, 8'd150, 8'd200, 1'b0, 1'b1, '{11'd0, 12'd3, 11'd0, 1'b0}},
            '{8'd91,  8'd159, 8'd209, 1'b0, 1'b1, '{11'd1, 12'd0, 11'd0, 1'b0}},
            '{8'd100, 8'd150, 8'd255, 1'b0, 1'b1, '{11'd2, 12'd1, 11'd2, 1'b1}}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_FRAME_WIDTH, 12'd3);
        write_reg(CFG_FRAME_HEIGHT, 12'd3);
        write_reg(CFG_BG_CHAN0, 12'd100);
        write_reg(CFG_BG_CHAN1, 12'd150);
        write_reg(CFG_BG_CHAN2, 12'd200);
        write_reg(CFG_TOLERANCE, 12'd10);
        i_cfg_valid <= 1'b0;
        foreach (directed_rows[i]) begin
            send_pixel(directed_rows[i].chan0, directed_rows[i].chan1,
                       directed_rows[i].chan2, directed_rows[i].frame_start,
                       directed_rows[i].typed, directed_rows[i].extent);
        end
        drain_extents();

        // Widest frame setting, a single row, every pixel counted as foreground.
        write_reg(CFG_FRAME_WIDTH, 12'd4095);
        write_reg(CFG_FRAME_HEIGHT, 12'd1);
        write_reg(CFG_TOLERANCE, 12'd0);
        i_cfg_valid <= 1'b0;
        for (int k = 0; k < WIDE_PIXELS; k++) begin
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), k == 0, 1'b0, NONE);
        end
        drain_extents();

        // Tall frame with two columns: one all background, one marked on
        // the second and the last row. No idling on either side here.
        calm = 1'b1;
        write_reg(CFG_FRAME_WIDTH, 12'd2);
        write_reg(CFG_FRAME_HEIGHT, 12'(TALL_ROWS));
        write_reg(CFG_BG_CHAN0, 12'd0);
        write_reg(CFG_BG_CHAN1, 12'd0);
        write_reg(CFG_BG_CHAN2, 12'd0);
        write_reg(CFG_TOLERANCE, 12'd100);
        i_cfg_valid <= 1'b0;
        for (int k = 0; k < 2 * TALL_ROWS; k++) begin
            hot = (k % 2 == 1) && (k / 2 == 1 || k / 2 == TALL_ROWS - 1);
            send_pixel(hot ? 8'd200 : 8'($urandom_range(99)), 8'($urandom_range(99)),
                       8'($urandom_range(99)), k == 0, 1'b0, NONE);
        end
        drain_extents();
        calm = 1'b0;

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            old_w = clamp_dim(cfg_width);
            calm  = ($urandom_range(3) == 0);
            case ($urandom_range(9))
                0:       w_val = 12'd0;
                1:       w_val = 12'd1;
                2:       w_val = 12'($urandom_range(13, 40));
                default: w_val = 12'($urandom_range(2, 12));
            endcase
            case ($urandom_range(7))
                0:       h_val = 12'd0;
                1:       h_val = 12'd1;
                default: h_val = 12'($urandom_range(2, 6));
            endcase
            case ($urandom_range(5))
                0:       tol_val = 9'd0;
                1:       tol_val = 9'd256;
                2:       tol_val = 9'($urandom_range(257, 511));
                3:       tol_val = 9'($urandom_range(256));
                default: tol_val = 9'($urandom_range(1, 40));
            endcase
            if ($urandom_range(3) != 0) write_reg(CFG_FRAME_WIDTH, w_val);
            if ($urandom_range(3) != 0) write_reg(CFG_FRAME_HEIGHT, h_val);
            if ($urandom_range(1)) write_reg(CFG_BG_CHAN0, 12'($urandom_range(4095)));
            if ($urandom_range(1)) write_reg(CFG_BG_CHAN1, 12'($urandom_range(4095)));
            if ($urandom_range(1)) write_reg(CFG_BG_CHAN2, 12'($urandom_range(4095)));
            if ($urandom_range(1))
                write_reg(CFG_TOLERANCE, {3'($urandom_range(7)), tol_val});
            i_cfg_valid <= 1'b0;

            // A wider frame needs a fresh first row before columns are read.
            start     = (clamp_dim(cfg_width) > old_w) || $urandom_range(1);
            phase_len = $urandom_range(30, 200);
            for (int k = 0; k < phase_len; k++) begin
                make_pixel(c0, c1, c2);
                send_pixel(c0, c1, c2, start || ($urandom_range(149) == 0), 1'b0, NONE);
                start = 1'b0;
                random_pixels++;
            end
            drain_extents();
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("column_foreground_extent_finder_core test passed");
        else
            $display("column_foreground_extent_finder_core test failed");
        $finish;
    end

endmodule
